// ===== design/duplicate_track_merge_macros.svh =====
// Assertion macros for the duplicate track merge block.
`ifndef DUPLICATE_TRACK_MERGE_MACROS_SVH
`define DUPLICATE_TRACK_MERGE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DTM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define DTM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define DTM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DTM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/dtm_pkg.sv =====
// ----------------------------------------------------------------------------
// dtm_pkg
// Types and constants shared by the duplicate track merge modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package dtm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_POS_GATE = 3'd0;
  localparam logic [2:0] REG_VEL_GATE = 3'd1;
  localparam logic [2:0] REG_AZ_GATE  = 3'd2;
  localparam logic [2:0] REG_PIT_GATE = 3'd3;
  localparam logic [2:0] REG_MIN_LIFE = 3'd4;

  localparam logic [15:0] POS_GATE_RST = 16'd160;
  localparam logic [15:0] VEL_GATE_RST = 16'd48;
  localparam logic [15:0] AZ_GATE_RST  = 16'd286;
  localparam logic [15:0] PIT_GATE_RST = 16'd214;
  localparam logic [15:0] MIN_LIFE_RST = 16'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // store the input beat at the fill count
    logic rd;         // read the pair (i, j) from memory
    logic eval;       // registered pair data is valid; evaluate it
    logic emit;       // present the result for position i
    logic clear;      // end of list: clear flags and count
  } dtm_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;       // store holds the maximum number of tracks
  } dtm_sts_t;

endpackage

// ===== design/duplicate_track_merge.sv =====
// ----------------------------------------------------------------------------
// duplicate_track_merge
// Collects a track list and flags duplicate tracks by pairwise gating.
// ----------------------------------------------------------------------------
// Each non-last track beat is stored while the block is idle. The beat with
// last set is stored too and starts the merge: every pair i < j is handled by
// a memory read of both tracks (ST_PAIR) and then an evaluation (ST_EVAL),
// with a pairless ST_PAIR step at the end of each row; then the results for
// the n stored tracks follow, one per cycle with out_valid, and ST_DONE clears.
// Busy stays high from the last beat until the clear; results cannot be stalled by the receiver.
`timescale 1ns / 1ps
module duplicate_track_merge #(
  parameter int MAX_TRACKS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic signed [23:0] in_pos_x,
  input  logic signed [23:0] in_pos_y,
  input  logic signed [23:0] in_pos_z,
  input  logic signed [15:0] in_vel_x,
  input  logic signed [15:0] in_vel_y,
  input  logic signed [15:0] in_vel_z,
  input  logic [23:0]        in_slant_range,
  input  logic signed [15:0] in_radial_speed,
  input  logic [31:0]        in_angles,
  input  logic [15:0]        in_lifetime,
  input  logic [15:0]        in_meas_id,
  input  logic               in_last,
  output logic               out_valid,
  output logic [5:0]         out_list_position,
  output logic               out_freed,
  output logic               out_final_res
);

  localparam int IW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CW = $clog2(MAX_TRACKS + 1);

  logic [15:0] pos_gate_r, vel_gate_r, az_gate_r, pit_gate_r, min_life_r;
  dtm_pkg::dtm_cmd_t cmd;
  dtm_pkg::dtm_sts_t sts;
  logic [CW-1:0] count;
  logic [IW-1:0] idx_i, idx_j;
  logic freed_bit, ov, ol;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_gate_r <= dtm_pkg::POS_GATE_RST;
      vel_gate_r <= dtm_pkg::VEL_GATE_RST;
      az_gate_r  <= dtm_pkg::AZ_GATE_RST;
      pit_gate_r <= dtm_pkg::PIT_GATE_RST;
      min_life_r <= dtm_pkg::MIN_LIFE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dtm_pkg::REG_POS_GATE: pos_gate_r <= cfg_data;
        dtm_pkg::REG_VEL_GATE: vel_gate_r <= cfg_data;
        dtm_pkg::REG_AZ_GATE:  az_gate_r  <= cfg_data;
        dtm_pkg::REG_PIT_GATE: pit_gate_r <= cfg_data;
        dtm_pkg::REG_MIN_LIFE: min_life_r <= cfg_data;
        default: ;
      endcase
    end
  end

  dtm_ctrl #(.IW(IW), .CW(CW)) u_ctrl (
    .clk, .rst_n, .start, .last(in_last), .busy, .count, .cmd,
    .idx_i, .idx_j, .out_valid(ov), .out_last(ol)
  );

  dtm_datapath #(.MAX_TRACKS(MAX_TRACKS), .IW(IW), .CW(CW)) u_dp (
    .clk, .rst_n, .cmd, .idx_i, .idx_j, .sts, .count,
    .pos_gate(pos_gate_r), .vel_gate(vel_gate_r), .az_gate(az_gate_r),
    .pit_gate(pit_gate_r), .min_life(min_life_r),
    .in_pos_x, .in_pos_y, .in_pos_z, .in_vel_x, .in_vel_y, .in_vel_z,
    .in_slant_range, .in_radial_speed, .in_angles, .in_lifetime, .in_meas_id,
    .freed_bit
  );

  // Result beat.
  assign out_valid = ov;
  assign out_list_position = 6'(idx_i);
  assign out_freed = freed_bit;
  assign out_final_res = ol;

endmodule

// ===== design/dtm_datapath.sv =====
// ----------------------------------------------------------------------------
// dtm_datapath
// Track memories, pair comparison and freed flags.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dtm_datapath #(
  parameter int MAX_TRACKS = 64,
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dtm_pkg::dtm_cmd_t    cmd,
  input  logic [IW-1:0]        idx_i,
  input  logic [IW-1:0]        idx_j,
  output dtm_pkg::dtm_sts_t    sts,
  output logic [CW-1:0]        count,
  input  logic [15:0]          pos_gate,
  input  logic [15:0]          vel_gate,
  input  logic [15:0]          az_gate,
  input  logic [15:0]          pit_gate,
  input  logic [15:0]          min_life,
  input  logic signed [23:0]   in_pos_x,
  input  logic signed [23:0]   in_pos_y,
  input  logic signed [23:0]   in_pos_z,
  input  logic signed [15:0]   in_vel_x,
  input  logic signed [15:0]   in_vel_y,
  input  logic signed [15:0]   in_vel_z,
  input  logic [23:0]          in_slant_range,
  input  logic signed [15:0]   in_radial_speed,
  input  logic [31:0]          in_angles,
  input  logic [15:0]          in_lifetime,
  input  logic [15:0]          in_meas_id,
  output logic                 freed_bit
);

  // One packed word per track.
  localparam int TW = 3*24 + 3*16 + 24 + 16 + 32 + 16 + 16;
  typedef logic [TW-1:0] trk_t;

  trk_t mem [MAX_TRACKS];
  trk_t rd_i_r, rd_j_r;
  logic [CW-1:0] count_r;
  logic [MAX_TRACKS-1:0] freed_r;
  logic [IW-1:0] ei_r, ej_r;

  assign count = count_r;
  assign sts.full = (count_r == CW'(MAX_TRACKS));
  assign freed_bit = freed_r[idx_i];

  // Memory write and registered dual read.
  always_ff @(posedge clk) begin
    if (cmd.load && !sts.full) begin
      mem[count_r[IW-1:0]] <= {in_pos_x, in_pos_y, in_pos_z, in_vel_x, in_vel_y,
                               in_vel_z, in_slant_range, in_radial_speed,
                               in_angles, in_lifetime, in_meas_id};
    end
    if (cmd.rd) begin
      rd_i_r <= mem[idx_i];
      rd_j_r <= mem[idx_j];
      ei_r   <= idx_i;
      ej_r   <= idx_j;
    end
  end

  // Absolute difference of two sign-extended values below a gate.
  function automatic logic below(input logic signed [24:0] a,
                                 input logic signed [24:0] b,
                                 input logic [16:0] g);
    logic signed [25:0] d;
    logic [25:0] m;
    begin
      d = 26'(a) - 26'(b);
      m = d[25] ? 26'(-d) : 26'(d);
      below = m < 26'(g);
    end
  endfunction

  // Unpacked fields of the pair.
  logic signed [23:0] pxi, pyi, pzi, pxj, pyj, pzj;
  logic signed [15:0] vxi, vyi, vzi, vxj, vyj, vzj, dpi, dpj;
  logic [23:0] rgi, rgj;
  logic [31:0] ani, anj;
  logic [15:0] agi, agj, mii, mij;
  logic cart, meas, dup, valid_pair;

  assign {pxi, pyi, pzi, vxi, vyi, vzi, rgi, dpi, ani, agi, mii} = rd_i_r;
  assign {pxj, pyj, pzj, vxj, vyj, vzj, rgj, dpj, anj, agj, mij} = rd_j_r;

  // Pair tests: Doppler uses 2|d| < gate, i.e. |d| compared doubled.
  always_comb begin
    logic signed [16:0] dd;
    logic [16:0] dm;
    dd = 17'(dpi) - 17'(dpj);
    dm = dd[16] ? 17'(-dd) : 17'(dd);
    cart = below(25'(pxi), 25'(pxj), {1'b0, pos_gate})
         & below(25'(pyi), 25'(pyj), {1'b0, pos_gate})
         & below(25'(pzi), 25'(pzj), {1'b0, pos_gate})
         & below(25'(vxi), 25'(vxj), {1'b0, vel_gate})
         & below(25'(vyi), 25'(vyj), {1'b0, vel_gate})
         & below(25'(vzi), 25'(vzj), {1'b0, vel_gate});
    meas = (mii == mij)
         & below($signed({1'b0, rgi}), $signed({1'b0, rgj}), {1'b0, pos_gate})
         & ({dm, 1'b0} < 18'(vel_gate))
         & below(25'($signed(ani[15:0])), 25'($signed(anj[15:0])), {1'b0, az_gate})
         & below(25'($signed(ani[31:16])), 25'($signed(anj[31:16])), {1'b0, pit_gate});
    valid_pair = (agi > min_life) && (agj > min_life);
    dup = valid_pair && (cart || meas);
  end

  // Fill count and freed flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      freed_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
      freed_r <= '0;
    end else begin
      if (cmd.load && !sts.full) count_r <= count_r + 1'b1;
      if (cmd.eval && dup) begin
        if (agi >= agj) freed_r[ej_r] <= 1'b1;
        else            freed_r[ei_r] <= 1'b1;
      end
    end
  end

endmodule

// ===== design/dtm_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtm_ctrl
// Sequencer: loads tracks, walks all pairs i < j, then emits results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "duplicate_track_merge_macros.svh"
module dtm_ctrl #(
  parameter int IW = 6,
  parameter int CW = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               last,
  output logic               busy,
  input  logic [CW-1:0]      count,
  output dtm_pkg::dtm_cmd_t  cmd,
  output logic [IW-1:0]      idx_i,
  output logic [IW-1:0]      idx_j,
  output logic               out_valid,
  output logic               out_last
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_PAIR = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic [CW-1:0] n;
  logic go;

  assign n = count;
  assign go = start && !busy;
  assign busy = (state_r != ST_IDLE);
  assign idx_i = i_r[IW-1:0];
  assign idx_j = j_r[IW-1:0];

  // Next state and pair counters.
  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    cmd = '0;
    out_valid = 1'b0;
    out_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cmd.load = go;
        if (go && last) begin
          state_nxt = ST_PAIR;
          i_nxt = '0;
          j_nxt = CW'(1);
        end
      end
      ST_PAIR: begin
        // n is final here; the count update of the last beat has landed.
        if (j_r >= n) begin
          if (i_r + CW'(2) >= n) begin
            state_nxt = (n == '0) ? ST_DONE : ST_EMIT;
            i_nxt = '0;
          end else begin
            i_nxt = i_r + 1'b1;
            j_nxt = i_r + CW'(2);
          end
        end else begin
          cmd.rd = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        j_nxt = j_r + 1'b1;
        state_nxt = ST_PAIR;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        out_valid = 1'b1;
        out_last = (i_r + 1'b1 == n);
        i_nxt = i_r + 1'b1;
        if (out_last) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.clear = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r <= '0;
      j_r <= '0;
    end else begin
      state_r <= state_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
    end
  end

  `DTM_ASSERT_IMP(a_emit_in_range, clk, rst_n, out_valid, i_r < n, "emit beyond count")
  `DTM_ASSERT_NXT(a_eval_after_rd, clk, rst_n, cmd.rd, state_r == ST_EVAL, "no eval after read")
  `DTM_ASSERT_IMP(a_pair_order, clk, rst_n, cmd.rd, i_r < j_r, "pair not ordered")
  `DTM_ASSERT_NXT(a_clear_idle, clk, rst_n, cmd.clear, !busy, "not idle after clear")

endmodule
